@@ rtl/core/chunked_body_decoder_macros.svh @@
`ifndef CHUNKED_BODY_DECODER_MACROS_SVH
`define CHUNKED_BODY_DECODER_MACROS_SVH

// checks that hold once reset has been released
`define CBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checks that hold through reset as well
`define CBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/cbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cbd_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam logic [15:0] MAX_LINE_RST = 16'd8192;

  localparam logic [7:0] CHR_CR   = 8'h0d;
  localparam logic [7:0] CHR_LF   = 8'h0a;
  localparam logic [7:0] CHR_SEMI = 8'h3b;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_LONG = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    kind_t       kind;
    logic [31:0] consumed_count;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/cbd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       restart;

  modport source (output valid, output in_byte, output restart, input ready);
  modport sink (input valid, input in_byte, input restart, output ready);
endinterface

interface cbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [31:0] consumed_count;

  modport source (output valid, output out_byte, output kind, output consumed_count,
                  input ready);
  modport sink (input valid, input out_byte, input kind, input consumed_count,
                output ready);
endinterface

interface cbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_line_length;

  modport source (output valid, output max_line_length, input ready);
  modport sink (input valid, input max_line_length, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cbd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "chunked_body_decoder_macros.svh"

module cbd_parser #(
  parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_valid,
  input  wire cbd_pkg::item_t  item,
  input  wire logic [15:0]     max_len,
  input  wire logic            out_ready,
  output logic                 take,
  output logic                 res_valid_r,
  output cbd_pkg::res_t        res_r
);

  typedef enum logic [2:0] {
    PH_DIGITS  = 3'd0,
    PH_EXT     = 3'd1,
    PH_SIZE_LF = 3'd2,
    PH_DATA    = 3'd3,
    PH_DATA_CR = 3'd4,
    PH_DATA_LF = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERR     = 3'd7
  } phase_t;

  phase_t                 ph_r, ph_nxt;
  logic [SIZE_BITS-1:0]   chunk_r, chunk_nxt;
  logic [15:0]            len_r, len_nxt;
  logic                   hd_r, hd_nxt;
  logic [31:0]            cons_r, cons_nxt;

  logic                   cnt_inc;
  logic                   fail;
  cbd_pkg::kind_t         fail_kind;
  logic                   emit;
  cbd_pkg::kind_t         kind;
  logic [7:0]             obyte;
  logic                   bad;
  logic [4:0]             hex;
  logic                   out_free;
  logic [7:0]             c;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end
    return r;
  endfunction

  assign c        = item.in_byte;
  assign hex      = hex_decode(c);
  assign out_free = !res_valid_r || out_ready;
  assign take     = item_valid && (!emit || out_free);

  always_comb begin
    ph_nxt    = ph_r;
    chunk_nxt = chunk_r;
    len_nxt   = len_r;
    hd_nxt    = hd_r;
    cnt_inc   = 1'b0;
    fail      = 1'b0;
    fail_kind = cbd_pkg::KIND_BAD;
    emit      = 1'b0;
    kind      = cbd_pkg::KIND_DATA;
    obyte     = 8'd0;
    bad       = 1'b0;
    if (item.restart) begin
      ph_nxt    = PH_DIGITS;
      chunk_nxt = '0;
      len_nxt   = 16'd0;
      hd_nxt    = 1'b0;
    end else begin
      unique case (ph_r)
        PH_DIGITS, PH_EXT: begin
          if (c == cbd_pkg::CHR_CR) begin
            if (!hd_r) begin
              fail = 1'b1;
            end else begin
              cnt_inc = 1'b1;
              ph_nxt  = PH_SIZE_LF;
            end
          end else if (len_r >= max_len) begin
            fail      = 1'b1;
            fail_kind = cbd_pkg::KIND_LONG;
          end else begin
            if (ph_r == PH_DIGITS) begin
              if (c == cbd_pkg::CHR_SEMI) begin
                ph_nxt = PH_EXT;
              end else if (!hex[4] || (|chunk_r[SIZE_BITS-1:SIZE_BITS-4])) begin
                bad = 1'b1;
              end else begin
                chunk_nxt = {chunk_r[SIZE_BITS-5:0], hex[3:0]};
                hd_nxt    = 1'b1;
              end
            end
            if (bad) begin
              fail = 1'b1;
            end else begin
              len_nxt = len_r + 16'd1;
              cnt_inc = 1'b1;
            end
          end
        end
        PH_SIZE_LF: begin
          if (c != cbd_pkg::CHR_LF) begin
            fail = 1'b1;
          end else begin
            cnt_inc = 1'b1;
            len_nxt = 16'd0;
            hd_nxt  = 1'b0;
            if (chunk_r == '0) begin
              ph_nxt = PH_DONE;
              emit   = 1'b1;
              kind   = cbd_pkg::KIND_DONE;
            end else begin
              ph_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          cnt_inc   = 1'b1;
          chunk_nxt = chunk_r - SIZE_BITS'(1);
          if (chunk_r == SIZE_BITS'(1)) begin
            ph_nxt = PH_DATA_CR;
          end
          emit  = 1'b1;
          obyte = c;
        end
        PH_DATA_CR: begin
          if (c != cbd_pkg::CHR_CR) begin
            fail = 1'b1;
          end else begin
            cnt_inc = 1'b1;
            ph_nxt  = PH_DATA_LF;
          end
        end
        PH_DATA_LF: begin
          if (c != cbd_pkg::CHR_LF) begin
            fail = 1'b1;
          end else begin
            cnt_inc   = 1'b1;
            ph_nxt    = PH_DIGITS;
            chunk_nxt = '0;
          end
        end
        PH_DONE, PH_ERR: begin
        end
        default: begin
        end
      endcase
      if (fail) begin
        ph_nxt = PH_ERR;
        emit   = 1'b1;
        kind   = fail_kind;
      end
    end
  end

  always_comb begin
    if (item.restart) begin
      cons_nxt = 32'd0;
    end else if (cnt_inc && (cons_r != 32'hffff_ffff)) begin
      cons_nxt = cons_r + 32'd1;
    end else begin
      cons_nxt = cons_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_DIGITS;
      chunk_r     <= '0;
      len_r       <= 16'd0;
      hd_r        <= 1'b0;
      cons_r      <= 32'd0;
      res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        ph_r    <= ph_nxt;
        chunk_r <= chunk_nxt;
        len_r   <= len_nxt;
        hd_r    <= hd_nxt;
        cons_r  <= cons_nxt;
      end
      if (take && emit) begin
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_r.out_byte       <= obyte;
      res_r.kind           <= kind;
      res_r.consumed_count <= cons_nxt;
    end
  end

  `CBD_ASSERT(a_stall_holds_result, (res_valid_r && !out_ready) |=> res_valid_r, "result dropped under stall")
  `CBD_ASSERT(a_err_silent, (item_valid && !item.restart && ph_r == PH_ERR) |-> !emit, "result after error")
  `CBD_ASSERT(a_data_from_data_phase, (emit && kind == cbd_pkg::KIND_DATA) |-> (ph_r == PH_DATA), "payload outside data phase")
  `CBD_ASSERT(a_count_monotonic, (take && !item.restart) |=> (cons_r >= $past(cons_r)), "byte count went backwards")
  `CBD_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!res_valid_r && cons_r == 32'd0), "reset did not clear state")

endmodule

`default_nettype wire

@@ rtl/core/chunked_body_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// HTTP chunked body decoder. Takes one raw body byte per transaction, parses each hex size
// line (extension after ';' skipped), passes exactly that many payload bytes out and strips
// the CR LF after them; a zero-size line ends the body with a completion result and later
// bytes are dropped. Oversize lines, bad hex, size overflow, an empty size or a missing CR
// or LF give one sticky error result until a restart transaction. Every result carries the
// saturating count of body bytes consumed. Throughput is one byte per clock unless a
// result stalls: a byte is held in the input register and parsed combinationally into the
// result register. While the result register is stalled, bytes that give no result keep
// flowing; the first byte that gives a result waits in the input register until the result
// is taken. max_line_length resets to 8192 and is written through cfg_if, always ready.
module chunked_body_decoder #(
  parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cbd_in_if.sink     in_if,
  cbd_out_if.source  out_if,
  cbd_cfg_if.sink    cfg_if
);

  logic            in_valid_r;
  cbd_pkg::item_t  item_r;
  logic [15:0]     max_len_r;
  logic            take;
  logic            res_valid_r;
  cbd_pkg::res_t   res_r;

  assign in_if.ready  = !in_valid_r || take;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      max_len_r  <= cbd_pkg::MAX_LINE_RST;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_valid_r <= 1'b1;
      end else if (take) begin
        in_valid_r <= 1'b0;
      end
      if (cfg_if.valid) begin
        max_len_r <= cfg_if.max_line_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.in_byte <= in_if.in_byte;
      item_r.restart <= in_if.restart;
    end
  end

  cbd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_valid_r),
    .item        (item_r),
    .max_len     (max_len_r),
    .out_ready   (out_if.ready),
    .take        (take),
    .res_valid_r (res_valid_r),
    .res_r       (res_r)
  );

  assign out_if.valid          = res_valid_r;
  assign out_if.out_byte       = res_r.out_byte;
  assign out_if.kind           = res_r.kind;
  assign out_if.consumed_count = res_r.consumed_count;

endmodule

`default_nettype wire

@@ tb/chunked_body_decoder_test.sv @@
`timescale 1ns / 1ps

module chunked_body_decoder_test;
  import cbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_SETTING = 50;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic [2:0] {
    AT_DIGITS, AT_EXT, AT_SIZE_LF, AT_DATA, AT_DATA_CR, AT_DATA_LF, AT_DONE, AT_FAILED
  } body_phase_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_RESTART, ROW_LIMIT} row_op_t;

  typedef struct {
    row_op_t     op;
    logic [15:0] value;
    bit          typed;
    kind_t       kind;
    logic [7:0]  exp_byte;
    logic [31:0] exp_count;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cbd_in_if  in_ch ();
  cbd_out_if out_ch ();
  cbd_cfg_if cfg_ch ();

  chunked_body_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #1 clk = ~clk;

  // decoder state as predicted
  body_phase_t p_phase = AT_DIGITS;
  logic [31:0] p_remaining = '0;
  logic [15:0] p_line_len = '0;
  logic [31:0] p_consumed = '0;
  bit          p_have_digit = 1'b0;
  logic [15:0] line_limit = MAX_LINE_RST;

  res_t        decoded_q[$];
  logic [7:0]  stream_q[$];
  int unsigned mismatches = 0;
  int unsigned live_items = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_hold = 0;
  bit          calm = 1'b0;

  // hex size, extension skip, payload pass-through, CR LF strip, zero-size end, restart, bad hex and line-limit errors
  row_t directed_rows [27] = '{
    '{ROW_BYTE,    "2",      1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    CHR_SEMI, 1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    "z",      1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    CHR_CR,   1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    CHR_LF,   1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    8'h00,    1'b1, KIND_DATA, 8'h00, 32'd6},
    '{ROW_BYTE,    8'hff,    1'b1, KIND_DATA, 8'hff, 32'd7},
    '{ROW_BYTE,    CHR_CR,   1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    CHR_LF,   1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    "0",      1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    CHR_CR,   1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    CHR_LF,   1'b1, KIND_DONE, 8'h00, 32'd12},
    '{ROW_BYTE,    8'ha5,    1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_RESTART, 8'hff,    1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    "g",      1'b1, KIND_BAD,  8'h00, 32'd0},
    '{ROW_BYTE,    "1",      1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_RESTART, 8'h00,    1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    CHR_CR,   1'b1, KIND_BAD,  8'h00, 32'd0},
    '{ROW_RESTART, 8'h00,    1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_LIMIT,   16'd1,    1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    "1",      1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    CHR_SEMI, 1'b1, KIND_LONG, 8'h00, 32'd1},
    '{ROW_RESTART, 8'h00,    1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_LIMIT,   16'd0,    1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_BYTE,    "5",      1'b1, KIND_LONG, 8'h00, 32'd0},
    '{ROW_RESTART, 8'h00,    1'b0, KIND_DATA, 8'h00, 32'd0},
    '{ROW_LIMIT,   16'd8192, 1'b0, KIND_DATA, 8'h00, 32'd0}
  };

  function automatic void queue_result(input res_t r);
    decoded_q = {decoded_q, r};
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    stream_q = {stream_q, b};
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic void count_one();
    if (p_consumed != 32'hffff_ffff) p_consumed++;
  endfunction

  function automatic bit raise_error(input kind_t k, output res_t r);
    p_phase = AT_FAILED;
    r.out_byte = 8'h00;
    r.kind = k;
    r.consumed_count = p_consumed;
    return 1'b1;
  endfunction

  // returns 1 when the byte yields a result
  function automatic bit decode_step(input logic [7:0] b, input bit rs, output res_t r);
    int d;
    r = '0;
    if (rs) begin
      p_phase = AT_DIGITS;
      p_remaining = '0;
      p_line_len = '0;
      p_consumed = '0;
      p_have_digit = 1'b0;
      return 1'b0;
    end
    case (p_phase)
      AT_DIGITS, AT_EXT: begin
        if (b == CHR_CR) begin
          if (!p_have_digit) return raise_error(KIND_BAD, r);
          count_one();
          p_phase = AT_SIZE_LF;
          return 1'b0;
        end
        if (p_line_len >= line_limit) return raise_error(KIND_LONG, r);
        if (p_phase == AT_DIGITS) begin
          if (b == CHR_SEMI) begin
            p_phase = AT_EXT;
          end else begin
            if (b >= "0" && b <= "9") d = b - 8'h30;
            else if (b >= "a" && b <= "f") d = b - 8'h57;
            else if (b >= "A" && b <= "F") d = b - 8'h37;
            else d = -1;
            if (d < 0) return raise_error(KIND_BAD, r);
            if (p_remaining[31:28] != 4'h0) return raise_error(KIND_BAD, r);
            p_remaining = {p_remaining[27:0], d[3:0]};
            p_have_digit = 1'b1;
          end
        end
        p_line_len++;
        count_one();
        return 1'b0;
      end
      AT_SIZE_LF: begin
        if (b != CHR_LF) return raise_error(KIND_BAD, r);
        count_one();
        p_line_len = '0;
        p_have_digit = 1'b0;
        if (p_remaining == '0) begin
          p_phase = AT_DONE;
          r.kind = KIND_DONE;
          r.consumed_count = p_consumed;
          return 1'b1;
        end
        p_phase = AT_DATA;
        return 1'b0;
      end
      AT_DATA: begin
        count_one();
        p_remaining--;
        if (p_remaining == '0) p_phase = AT_DATA_CR;
        r.out_byte = b;
        r.kind = KIND_DATA;
        r.consumed_count = p_consumed;
        return 1'b1;
      end
      AT_DATA_CR: begin
        if (b != CHR_CR) return raise_error(KIND_BAD, r);
        count_one();
        p_phase = AT_DATA_LF;
        return 1'b0;
      end
      AT_DATA_LF: begin
        if (b != CHR_LF) return raise_error(KIND_BAD, r);
        count_one();
        p_phase = AT_DIGITS;
        p_remaining = '0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit rs, input bit typed,
                           input res_t typed_res);
    res_t r;
    bit hit;
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.restart <= rs;
    do @(posedge clk); while (!in_ch.ready);
    if (rs || (p_phase != AT_DONE && p_phase != AT_FAILED)) live_items++;
    hit = decode_step(b, rs, r);
    if (typed) queue_result(typed_res);
    else if (hit) queue_result(r);
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_line_limit(input logic [15:0] v);
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_line_length <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    line_limit = v;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] ext_byte();
    logic [7:0] b;
    b = $urandom;
    if (b == CHR_CR) b = 8'h20;
    return b;
  endfunction

  task automatic add_size_line(input logic [31:0] sz);
    int nib;
    int i;
    nib = 8;
    while (nib > 1 && sz[(nib-1)*4 +: 4] == 4'h0) nib--;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_byte("0");
    for (i = nib - 1; i >= 0; i--) add_byte(hex_char(sz[i*4 +: 4]));
    if ($urandom_range(0, 3) == 0) begin
      add_byte(CHR_SEMI);
      repeat ($urandom_range(0, 5)) add_byte(ext_byte());
    end
    add_byte(CHR_CR);
    add_byte(CHR_LF);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 4))
      0: return hex_char($urandom);
      1: return CHR_CR;
      2: return CHR_LF;
      3: return CHR_SEMI;
      default: return $urandom;
    endcase
  endfunction

  // one body: mostly well formed, some corrupted, some plain noise
  task automatic feed_body();
    int unsigned m;
    int unsigned sz;
    int unsigned r;
    int unsigned i;
    stream_q.delete();
    m = $urandom_range(0, 99);
    if (m >= 95) begin
      repeat ($urandom_range(1, 10)) add_byte(noise_byte());
    end else begin
      if (m >= 85 && m < 90) begin
        // nine significant digits do not fit
        add_byte(hex_char($urandom_range(1, 15)));
        repeat (8) add_byte(hex_char($urandom));
        add_byte(CHR_CR);
        add_byte(CHR_LF);
      end else if (m >= 90) begin
        if ($urandom_range(0, 1)) begin
          add_byte(CHR_SEMI);
          add_byte(ext_byte());
        end
        add_byte(CHR_CR);
        add_byte(CHR_LF);
      end
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 99);
        if (r < 80) sz = $urandom_range(1, 8);
        else if (r < 95) sz = $urandom_range(9, 40);
        else sz = $urandom_range(41, 200);
        add_size_line(sz);
        repeat (sz) add_byte($urandom);
        add_byte(CHR_CR);
        add_byte(CHR_LF);
      end
      add_size_line(0);
      repeat ($urandom_range(0, 3)) add_byte($urandom);
      if (m >= 70 && m < 80) stream_q[$urandom_range(0, stream_q.size() - 1)] = $urandom;
      else if (m >= 80 && m < 85) stream_q.delete($urandom_range(0, stream_q.size() - 1));
    end
    push_byte($urandom, 1'b1, 1'b0, '0);
    for (i = 0; i < stream_q.size(); i++) begin
      if ($urandom_range(0, 199) == 0) push_byte($urandom, 1'b1, 1'b0, '0);
      push_byte(stream_q[i], 1'b0, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      sink_hold <= gap_len();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected transaction: kind %0d out_byte %0h consumed_count %0d",
               out_ch.kind, out_ch.out_byte, out_ch.consumed_count);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          mismatches++;
        end
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.consumed_count !== want.consumed_count) begin
          $error("consumed_count: expected %0d, got %0d", want.consumed_count,
                 out_ch.consumed_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    row_t row;
    res_t typed_res;
    logic [15:0] limits [7];
    int ph;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_line_length = MAX_LINE_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.op)
        ROW_LIMIT: write_line_limit(row.value);
        ROW_RESTART: push_byte(row.value[7:0], 1'b1, 1'b0, '0);
        default: begin
          typed_res.out_byte = row.exp_byte;
          typed_res.kind = row.kind;
          typed_res.consumed_count = row.exp_count;
          push_byte(row.value[7:0], 1'b0, row.typed, typed_res);
        end
      endcase
    end

    limits = '{16'hffff, 16'd0, 16'd1, 16'($urandom_range(2, 12)), MAX_LINE_RST,
               16'($urandom_range(13, 65534)), 16'd3};
    for (ph = 0; ph < 7; ph++) begin
      write_line_limit(limits[ph]);
      live_items = 0;
      while (live_items < ITEMS_PER_SETTING) begin
        calm = (ph == 4) || ($urandom_range(0, 5) == 0);
        feed_body();
      end
    end

    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
